/* hw/rtl/salc_pkg.sv */
// Shared constants, types and helper functions for the syscall allowlist block.
// No dependencies; every other file refers to this package by scoped names.
package salc_pkg;

  localparam int ENTRIES    = 32;
  localparam int SLOTS      = 16;
  localparam int NAME_BYTES = 32;

  localparam int WORD_W      = 64;
  localparam int KEY_W       = 4 * WORD_W;
  localparam int ID_W        = 10;
  localparam int PID_W       = 22;
  localparam int MODE_W      = 2;
  localparam int VERDICT_W   = 3;
  localparam int WATCH_N     = 16;
  localparam int KNOWN_W     = $clog2(WATCH_N + 1);
  localparam int ENTRY_W     = $clog2(ENTRIES);
  localparam int ENTRY_OUT_W = $clog2(ENTRIES + 1);
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int CALL_AW     = ENTRY_W + SLOT_W;
  localparam int CALL_DEPTH  = ENTRIES * (1 << SLOT_W);

  localparam logic [MODE_W-1:0] MODE_LEARN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENFORCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MONITOR = 2'd2;

  localparam logic [VERDICT_W-1:0] V_ALLOWED  = 3'd0;
  localparam logic [VERDICT_W-1:0] V_LEARNED  = 3'd1;
  localparam logic [VERDICT_W-1:0] V_KNOWN    = 3'd2;
  localparam logic [VERDICT_W-1:0] V_BAD_CALL = 3'd3;
  localparam logic [VERDICT_W-1:0] V_BAD_FUNC = 3'd4;
  localparam logic [VERDICT_W-1:0] V_DROPPED  = 3'd5;

  localparam logic [WATCH_N-1:0][ID_W-1:0] WATCHED = {
    10'd263, 10'd257, 10'd92, 10'd90, 10'd87, 10'd84, 10'd82, 10'd63,
    10'd62,  10'd59,  10'd50, 10'd49, 10'd42, 10'd41, 10'd57, 10'd1
  };

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
    logic [KEY_W-1:0]   key;
  } name_wr_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [ENTRY_W-1:0] hit_idx;
    logic               free;
    logic [ENTRY_W-1:0] free_idx;
  } name_res_t;

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] entry;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [CNT_W-1:0]   used;
  } call_wr_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [CNT_W-1:0] used;
  } call_res_t;

  // Bytes of name word w that take part in the compare.
  function automatic logic [WORD_W-1:0] word_mask(input int w);
    logic [WORD_W-1:0] m;
    int keep;
    m = '0;
    keep = NAME_BYTES - 8 * w;
    for (int b = 0; b < 8; b++) begin
      if (b < keep) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [KNOWN_W-1:0] known_pos(input logic [ID_W-1:0] id);
    logic [KNOWN_W-1:0] pos;
    pos = KNOWN_W'(WATCH_N);
    for (int k = WATCH_N - 1; k >= 0; k--) begin
      if (WATCHED[k] == id) pos = KNOWN_W'(k);
    end
    return pos;
  endfunction

endpackage

/* hw/rtl/salc_ifs.sv */
// Valid/ready channel interfaces for events, results and the mode register.
// Depends on salc_pkg for field widths.
interface salc_evt_if;
  logic                            valid;
  logic                            ready;
  logic [salc_pkg::WORD_W-1:0]     name_word0;
  logic [salc_pkg::WORD_W-1:0]     name_word1;
  logic [salc_pkg::WORD_W-1:0]     name_word2;
  logic [salc_pkg::WORD_W-1:0]     name_word3;
  logic [salc_pkg::ID_W-1:0]       syscall_number;
  logic [salc_pkg::PID_W-1:0]      process_id;
  modport source (output valid, name_word0, name_word1, name_word2, name_word3,
                  syscall_number, process_id, input ready);
  modport sink   (input valid, name_word0, name_word1, name_word2, name_word3,
                  syscall_number, process_id, output ready);
endinterface

interface salc_res_if;
  logic                               valid;
  logic                               ready;
  logic [salc_pkg::VERDICT_W-1:0]     verdict;
  logic                               kill_request;
  logic [salc_pkg::KNOWN_W-1:0]       known_index;
  logic [salc_pkg::ENTRY_OUT_W-1:0]   entry_index;
  logic [salc_pkg::PID_W-1:0]         pid_out;
  modport source (output valid, verdict, kill_request, known_index, entry_index,
                  pid_out, input ready);
  modport sink   (input valid, verdict, kill_request, known_index, entry_index,
                  pid_out, output ready);
endinterface

interface salc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [salc_pkg::MODE_W-1:0]   op_mode;
  modport source (output valid, op_mode, input ready);
  modport sink   (input valid, op_mode, output ready);
endinterface

/* hw/rtl/salc_name_table.sv */
// Name key memory with entry valid bits and a sequential matching scan.
// Depends on salc_pkg.
module salc_name_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [salc_pkg::KEY_W-1:0]   key,
  input  salc_pkg::name_wr_t           wr,
  output salc_pkg::name_res_t          res
);

  logic [salc_pkg::KEY_W-1:0]   mem [salc_pkg::ENTRIES];
  logic [salc_pkg::ENTRIES-1:0] entry_valid;
  logic [salc_pkg::KEY_W-1:0]   rd_data;
  logic [salc_pkg::ENTRY_W-1:0] scan_idx;
  logic [salc_pkg::ENTRY_W-1:0] rd_idx;
  logic                         issuing;
  logic                         rd_vld;
  logic                         done;
  logic                         hit;
  logic [salc_pkg::ENTRY_W-1:0] hit_idx;
  logic                         free;
  logic [salc_pkg::ENTRY_W-1:0] free_idx;
  logic                         scan_last;
  logic                         rd_last;

  assign scan_last = (scan_idx == salc_pkg::ENTRY_W'(salc_pkg::ENTRIES - 1));
  assign rd_last   = (rd_idx == salc_pkg::ENTRY_W'(salc_pkg::ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.key;
    rd_data <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      issuing     <= 1'b0;
      rd_vld      <= 1'b0;
      done        <= 1'b0;
    end else begin
      rd_vld <= issuing;
      rd_idx <= scan_idx;
      done   <= rd_vld && rd_last;
      if (start) begin
        scan_idx <= '0;
        issuing  <= 1'b1;
        hit      <= 1'b0;
        free     <= 1'b0;
      end else if (issuing) begin
        if (scan_last) issuing <= 1'b0;
        else scan_idx <= scan_idx + 1'b1;
      end
      if (rd_vld) begin
        if (entry_valid[rd_idx]) begin
          if (!hit && rd_data == key) begin
            hit     <= 1'b1;
            hit_idx <= rd_idx;
          end
        end else if (!free) begin
          free     <= 1'b1;
          free_idx <= rd_idx;
        end
      end
      if (wr.en) entry_valid[wr.addr] <= 1'b1;
    end
  end

  assign res.done     = done;
  assign res.hit      = hit;
  assign res.hit_idx  = hit_idx;
  assign res.free     = free;
  assign res.free_idx = free_idx;

`ifndef NO_ASSERTIONS
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rd_vld) && $past(rd_last))
    else $error("name scan done without last read");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !issuing && !rd_vld)
    else $error("name scan restarted while busy");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !issuing && !rd_vld)
    else $error("name write during scan");
`endif

endmodule

/* hw/rtl/salc_call_table.sv */
// Allowed syscall memory with per-entry slot counts and a sequential slot scan.
// Depends on salc_pkg.
module salc_call_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [salc_pkg::ENTRY_W-1:0] entry,
  input  logic [salc_pkg::ID_W-1:0]    id,
  input  salc_pkg::call_wr_t           wr,
  output salc_pkg::call_res_t          res
);

  logic [salc_pkg::ID_W-1:0]    mem [salc_pkg::CALL_DEPTH];
  logic [salc_pkg::CNT_W-1:0]   slots_used [salc_pkg::ENTRIES];
  logic [salc_pkg::ID_W-1:0]    rd_data;
  logic [salc_pkg::CNT_W-1:0]   limit;
  logic [salc_pkg::CNT_W-1:0]   slot_idx;
  logic [salc_pkg::CALL_AW-1:0] rd_addr;
  logic                         issuing;
  logic                         rd_vld;
  logic                         rd_last;
  logic                         done;
  logic                         found;
  logic                         slot_last;

  assign rd_addr   = {entry, slot_idx[salc_pkg::SLOT_W-1:0]};
  assign slot_last = (slot_idx == limit - salc_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.entry, wr.slot}] <= wr.id;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < salc_pkg::ENTRIES; e++) slots_used[e] <= '0;
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      rd_vld  <= issuing;
      rd_last <= issuing && slot_last;
      done    <= 1'b0;
      if (start) begin
        limit    <= slots_used[entry];
        slot_idx <= '0;
        found    <= 1'b0;
        if (slots_used[entry] == '0) done <= 1'b1;
        else issuing <= 1'b1;
      end else if (issuing) begin
        if (slot_last) issuing <= 1'b0;
        else slot_idx <= slot_idx + 1'b1;
      end
      if (rd_vld) begin
        if (rd_data == id) found <= 1'b1;
        if (rd_last) done <= 1'b1;
      end
      if (wr.en) slots_used[wr.entry] <= wr.used;
    end
  end

  assign res.done  = done;
  assign res.found = found;
  assign res.used  = limit;

`ifndef NO_ASSERTIONS
  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    issuing |-> limit != '0 && limit <= salc_pkg::CNT_W'(salc_pkg::SLOTS))
    else $error("slot scan limit out of range");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !issuing && !rd_vld)
    else $error("slot scan restarted while busy");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !issuing && !rd_vld && wr.used <= salc_pkg::CNT_W'(salc_pkg::SLOTS))
    else $error("slot write during scan or count overflow");
`endif

endmodule

/* hw/rtl/syscall_allowlist_learn_check.sv */
// Top level: event intake, scan sequencing, learn/check decision and result register.
// Depends on salc_pkg, salc_ifs, salc_name_table and salc_call_table.
//
//  channel | dir | payload                                             | transaction when
//  evt     | in  | name_word0..3, syscall_number, process_id           | evt.valid & evt.ready
//  res     | out | verdict, kill_request, known_index, entry_index, pid | res.valid & res.ready
//  cfg     | in  | op_mode                                             | cfg.valid & cfg.ready
//
// One event at a time: the name scan reads all ENTRIES entries, the slot scan of a matched
// entry reads its n slots (n = its slot count), then the block decides and returns to idle;
// an unknown name goes from the name scan straight to the decision, with no slot scan.
// Both scans are bound by the single read port of each memory. rst is synchronous and
// clears mode, valid bits and slot counts at once. A result waits in its register while
// the next event is taken; the decision stalls only if the previous result has not left.
module syscall_allowlist_learn_check (
  input  logic            clk,
  input  logic            rst,
  salc_evt_if.sink        evt,
  salc_res_if.source      res,
  salc_cfg_if.sink        cfg
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_NAME   = 4'b0010,
    S_CALL   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t                           state;
  logic [salc_pkg::MODE_W-1:0]      op_mode;
  logic [salc_pkg::KEY_W-1:0]       key;
  logic [salc_pkg::ID_W-1:0]        id;
  logic [salc_pkg::PID_W-1:0]       pid;
  logic                             evt_take;
  logic                             name_start;
  logic                             call_start;
  logic                             decide_fire;
  logic                             learn;
  salc_pkg::name_res_t              name_res;
  salc_pkg::call_res_t              call_res;
  salc_pkg::name_wr_t               name_wr;
  salc_pkg::call_wr_t               call_wr;
  logic                             row_room;
  logic [salc_pkg::VERDICT_W-1:0]   verdict_next;
  logic [salc_pkg::ENTRY_OUT_W-1:0] entry_next;

  logic                             res_valid;
  logic [salc_pkg::VERDICT_W-1:0]   res_verdict;
  logic                             res_kill;
  logic [salc_pkg::KNOWN_W-1:0]     res_known;
  logic [salc_pkg::ENTRY_OUT_W-1:0] res_entry;
  logic [salc_pkg::PID_W-1:0]       res_pid;

  assign cfg.ready = 1'b1;
  assign evt.ready = (state == S_IDLE);
  assign evt_take  = evt.valid && evt.ready;
  assign name_start = evt_take;
  assign call_start = (state == S_NAME) && name_res.done && name_res.hit;
  assign decide_fire = (state == S_DECIDE) && (!res_valid || res.ready);
  assign learn = (op_mode == salc_pkg::MODE_LEARN);
  assign row_room = call_res.used < salc_pkg::CNT_W'(salc_pkg::SLOTS);

  always_ff @(posedge clk) begin
    if (rst) op_mode <= salc_pkg::MODE_LEARN;
    else if (cfg.valid && cfg.ready) op_mode <= cfg.op_mode;
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      key <= {evt.name_word3 & salc_pkg::word_mask(3), evt.name_word2 & salc_pkg::word_mask(2),
              evt.name_word1 & salc_pkg::word_mask(1), evt.name_word0 & salc_pkg::word_mask(0)};
      id  <= evt.syscall_number;
      pid <= evt.process_id;
    end
  end

  salc_name_table u_name (
    .clk   (clk),
    .rst   (rst),
    .start (name_start),
    .key   (key),
    .wr    (name_wr),
    .res   (name_res)
  );

  salc_call_table u_call (
    .clk   (clk),
    .rst   (rst),
    .start (call_start),
    .entry (name_res.hit_idx),
    .id    (id),
    .wr    (call_wr),
    .res   (call_res)
  );

  always_comb begin
    name_wr = '0;
    call_wr = '0;
    name_wr.addr = name_res.free_idx;
    name_wr.key  = key;
    call_wr.id   = id;
    entry_next   = salc_pkg::ENTRY_OUT_W'(salc_pkg::ENTRIES);
    if (learn) begin
      if (name_res.hit) begin
        entry_next    = salc_pkg::ENTRY_OUT_W'(name_res.hit_idx);
        call_wr.entry = name_res.hit_idx;
        call_wr.slot  = call_res.used[salc_pkg::SLOT_W-1:0];
        call_wr.used  = call_res.used + 1'b1;
        if (call_res.found) begin
          verdict_next = salc_pkg::V_KNOWN;
        end else if (row_room) begin
          verdict_next = salc_pkg::V_LEARNED;
          call_wr.en   = decide_fire;
        end else begin
          verdict_next = salc_pkg::V_DROPPED;
        end
      end else if (name_res.free) begin
        entry_next    = salc_pkg::ENTRY_OUT_W'(name_res.free_idx);
        verdict_next  = salc_pkg::V_LEARNED;
        name_wr.en    = decide_fire;
        call_wr.en    = decide_fire;
        call_wr.entry = name_res.free_idx;
        call_wr.slot  = '0;
        call_wr.used  = salc_pkg::CNT_W'(1);
      end else begin
        verdict_next = salc_pkg::V_DROPPED;
      end
    end else if (name_res.hit) begin
      entry_next   = salc_pkg::ENTRY_OUT_W'(name_res.hit_idx);
      verdict_next = call_res.found ? salc_pkg::V_ALLOWED : salc_pkg::V_BAD_CALL;
    end else begin
      verdict_next = salc_pkg::V_BAD_FUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (evt_take) state <= S_NAME;
        end
        S_NAME: begin
          if (name_res.done) state <= name_res.hit ? S_CALL : S_DECIDE;
        end
        S_CALL: begin
          if (call_res.done) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (decide_fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (decide_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_fire) begin
      res_verdict <= verdict_next;
      res_kill    <= (op_mode == salc_pkg::MODE_ENFORCE) &&
                     (verdict_next != salc_pkg::V_ALLOWED);
      res_known   <= salc_pkg::known_pos(id);
      res_entry   <= entry_next;
      res_pid     <= pid;
    end
  end

  assign res.valid        = res_valid;
  assign res.verdict      = res_verdict;
  assign res.kill_request = res_kill;
  assign res.known_index  = res_known;
  assign res.entry_index  = res_entry;
  assign res.pid_out      = res_pid;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");
  a_kill_reject: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kill_request |->
      res.verdict == salc_pkg::V_BAD_CALL || res.verdict == salc_pkg::V_BAD_FUNC)
    else $error("kill request on a non-rejected event");
  a_call_done_state: assert property (@(posedge clk) disable iff (rst)
    call_res.done |-> state == S_CALL)
    else $error("slot scan finished outside its state");
  a_bad_func_no_entry: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.verdict == salc_pkg::V_BAD_FUNC |->
      res.entry_index == salc_pkg::ENTRY_OUT_W'(salc_pkg::ENTRIES))
    else $error("unknown function reported with an entry");
`endif

endmodule
